[design/ptw_pkg.sv]
package ptw_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 8;
   localparam int CNT_W = $clog2(DATA_WIDTH);

   typedef logic [DATA_WIDTH-1:0] word_type;

   // Request to the bit-serial divider.
   typedef struct packed {
      logic     start;
      word_type dividend;
      word_type divisor;
   } div_req_type;

   // Response from the bit-serial divider; quotient and remainder hold until the next start.
   typedef struct packed {
      logic     done;
      word_type quotient;
      word_type remainder;
   } div_rsp_type;

endpackage

[design/ptw_divider.sv]
module ptw_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  ptw_pkg::div_req_type div_req,
   output ptw_pkg::div_rsp_type div_rsp
);
   import ptw_pkg::*;

   word_type               rem_ff, rem_in;
   word_type               quo_ff, quo_in;
   word_type               div_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic                   busy_ff;
   logic                   done_ff;
   logic [DATA_WIDTH:0]    trial;
   logic [DATA_WIDTH:0]    diff;
   logic                   fits;

   // Restoring division: one dividend bit enters the partial remainder per cycle,
   // and one quotient bit leaves into the vacated low end of the shift register.
   always_comb begin
      trial  = {rem_ff, quo_ff[DATA_WIDTH-1]};
      diff   = trial - {1'b0, div_ff};
      fits   = trial >= {1'b0, div_ff};
      rem_in = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
      quo_in = {quo_ff[DATA_WIDTH-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DATA_WIDTH - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= '0;
         quo_ff <= div_req.dividend;
         div_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

[design/prime_test_six_k_wheel.sv]
// Primality test of a signed integer by trial division on the 6k +/- 1 wheel.
// The req_ channel carries one candidate per transaction; the rsp_ channel
// returns exactly one transaction per candidate with bit 0 set when it is prime.
// Negative values, zero and one are reported not prime; two and three prime.
// Every other candidate is first divided by 6 and, if the remainder is 1 or 5, then
// by the divisor pairs d and d+2 for d = 5, 11, 17, ... while d <= n / d. A single
// bit-serial restoring divider does all of the work, one quotient bit per cycle.
// The number of wheel steps grows to about 7700 for 31-bit primes.
// One candidate is processed at a time. A new candidate is taken as soon as the
// previous result has moved into the output register, even while that result
// still waits for rsp_tready; a stalled receiver holds the result and, once a
// second result is ready, holds the block as well.
// Reset is synchronous and clears all control state; nothing else needs clearing.
module prime_test_six_k_wheel (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ptw_pkg::REQ_TDATA_W-1:0] req_tdata,  // [31:0] candidate
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ptw_pkg::RSP_TDATA_W-1:0] rsp_tdata   // [0] is_prime, [7:1] zero
);
   import ptw_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MOD6,
      S_DIV_LO,
      S_DIV_HI,
      S_RESULT
   } state_type;

   state_type    state_ff;
   word_type     n_ff;
   word_type     d_ff;
   logic         prime_ff;
   logic         rsp_tvalid_ff;
   logic         rsp_prime_ff;
   div_req_type  div_req_ff;
   div_rsp_type  div_rsp;
   word_type     cand;
   logic         accept;
   logic         out_free;

   assign cand       = DATA_WIDTH'(req_tdata);
   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   ptw_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req_ff),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         rsp_tvalid_ff    <= 1'b0;
         div_req_ff.start <= 1'b0;
      end else begin
         div_req_ff.start <= 1'b0;
         // In the result state the output register is reloaded below instead.
         if (rsp_tvalid_ff && rsp_tready && state_ff != S_RESULT) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  n_ff <= cand;
                  if (cand[DATA_WIDTH-1] || cand <= DATA_WIDTH'(1)) begin
                     prime_ff <= 1'b0;
                     state_ff <= S_RESULT;
                  end else if (cand == DATA_WIDTH'(2) || cand == DATA_WIDTH'(3)) begin
                     prime_ff <= 1'b1;
                     state_ff <= S_RESULT;
                  end else begin
                     div_req_ff.start    <= 1'b1;
                     div_req_ff.dividend <= cand;
                     div_req_ff.divisor  <= DATA_WIDTH'(6);
                     state_ff            <= S_MOD6;
                  end
               end
            end
            S_MOD6: begin
               if (div_rsp.done) begin
                  if (div_rsp.remainder == DATA_WIDTH'(1) ||
                      div_rsp.remainder == DATA_WIDTH'(5)) begin
                     d_ff                <= DATA_WIDTH'(5);
                     div_req_ff.start    <= 1'b1;
                     div_req_ff.dividend <= n_ff;
                     div_req_ff.divisor  <= DATA_WIDTH'(5);
                     state_ff            <= S_DIV_LO;
                  end else begin
                     prime_ff <= 1'b0;
                     state_ff <= S_RESULT;
                  end
               end
            end
            S_DIV_LO: begin
               if (div_rsp.done) begin
                  // The loop bound d <= n / d comes from the same division.
                  if (d_ff > div_rsp.quotient) begin
                     prime_ff <= 1'b1;
                     state_ff <= S_RESULT;
                  end else if (div_rsp.remainder == '0) begin
                     prime_ff <= 1'b0;
                     state_ff <= S_RESULT;
                  end else begin
                     div_req_ff.start    <= 1'b1;
                     div_req_ff.dividend <= n_ff;
                     div_req_ff.divisor  <= d_ff + DATA_WIDTH'(2);
                     state_ff            <= S_DIV_HI;
                  end
               end
            end
            S_DIV_HI: begin
               if (div_rsp.done) begin
                  if (div_rsp.remainder == '0) begin
                     prime_ff <= 1'b0;
                     state_ff <= S_RESULT;
                  end else begin
                     d_ff                <= d_ff + DATA_WIDTH'(6);
                     div_req_ff.start    <= 1'b1;
                     div_req_ff.dividend <= n_ff;
                     div_req_ff.divisor  <= d_ff + DATA_WIDTH'(6);
                     state_ff            <= S_DIV_LO;
                  end
               end
            end
            S_RESULT: begin
               if (out_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_prime_ff  <= prime_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - 1)'(0), rsp_prime_ff};

`ifndef SYNTHESIS
   // The divider only finishes while the controller waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_MOD6 || state_ff == S_DIV_LO || state_ff == S_DIV_HI))
      else $error("divider finished while no division was pending");

   // A negative candidate goes straight to a not-prime result.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_tdata[DATA_WIDTH-1]) |=> (state_ff == S_RESULT && !prime_ff))
      else $error("negative candidate not rejected at once");

   // A division never completes in the cycle in which it is launched.
   assert property (@(posedge clock) disable iff (reset)
      div_req_ff.start |-> !div_rsp.done)
      else $error("divider completed in the launch cycle");

   // A result leaves the result state only into a free output register.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESULT && !out_free) |=> state_ff == S_RESULT)
      else $error("result dropped while the output register was full");
`endif

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
   import ptw_pkg::*;

   localparam int CYCLE_LIMIT = 6_000_000;
   localparam int HOLD_CYCLES = 200;
   localparam int PROBE_COUNT = 23;

   typedef struct packed {
      word_type candidate;
      bit       known;
      bit       prime;
   } probe_type;

   typedef struct {
      word_type candidate;
      bit       prime;
   } verdict_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   verdict_type verdict_q[$];
   verdict_type verdict_head;
   int          mismatch_count = 0;
   int unsigned send_idle_pct = 33;
   int unsigned rsp_idle_pct = 75;
   bit          hold_request = 0;

   // Rows with a typed-in answer are trivial or extreme; the others go to the predictor.
   probe_type probes [PROBE_COUNT] = '{
      '{32'd0,           1'b1, 1'b0},
      '{32'd1,           1'b1, 1'b0},
      '{32'd2,           1'b1, 1'b1},
      '{32'd3,           1'b1, 1'b1},
      '{32'd4,           1'b1, 1'b0},
      '{32'hFFFF_FFFF,   1'b1, 1'b0},
      '{32'h8000_0000,   1'b1, 1'b0},
      '{32'hAAAA_AAAA,   1'b1, 1'b0},
      '{32'h7FFF_FFFE,   1'b1, 1'b0},
      '{32'h7FFF_FFFF,   1'b1, 1'b1},
      '{32'd5,           1'b0, 1'b0},
      '{32'd7,           1'b0, 1'b0},
      '{32'd9,           1'b0, 1'b0},
      '{32'd25,          1'b0, 1'b0},
      '{32'd35,          1'b0, 1'b0},
      '{32'd49,          1'b0, 1'b0},
      '{32'd121,         1'b0, 1'b0},
      '{32'd143,         1'b0, 1'b0},
      '{32'd65521,       1'b0, 1'b0},
      '{32'd1000003,     1'b0, 1'b0},
      '{32'd1042441,     1'b0, 1'b0},
      '{32'h5555_5555,   1'b0, 1'b0},
      '{32'h7FFF_FFFD,   1'b0, 1'b0}
   };

   prime_test_six_k_wheel dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic bit prime_by_wheel(word_type candidate);
      longint unsigned n;
      longint unsigned d;
      if (candidate[DATA_WIDTH-1]) return 1'b0;
      n = candidate;
      if (n <= 1) return 1'b0;
      if (n == 2 || n == 3) return 1'b1;
      if (n % 6 != 1 && n % 6 != 5) return 1'b0;
      for (d = 5; d <= n / d; d += 6) begin
         if (n % d == 0 || n % (d + 2) == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Values are kept cheap for the divider: large ones always carry a small factor.
   function automatic word_type random_candidate();
      int unsigned kind;
      int unsigned factor;
      word_type    v;
      kind = $urandom_range(99);
      if (kind < 10) begin
         v = $urandom_range(40);
      end else if (kind < 40) begin
         v = $urandom_range(65535);
      end else if (kind < 45) begin
         v = $urandom_range(1048575);
      end else if (kind < 60) begin
         v = $urandom | 32'h8000_0000;
      end else if (kind < 75) begin
         factor = $urandom_range(13, 2);
         v = $urandom & 32'h7FFF_FFFF;
         v = v - v % factor;
      end else begin
         factor = $urandom_range(300, 2);
         v = factor * $urandom_range(32'h7FFF_FFFF / factor, 1);
      end
      return v;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic send_candidate(input word_type candidate, input bit prime);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= candidate;
      do @(posedge clock); while (!req_tready);
      verdict_q.push_back('{candidate, prime});
   endtask

   task automatic send_random(input int count);
      word_type v;
      for (int k = 0; k < count; k++) begin
         v = random_candidate();
         send_candidate(v, prime_by_wheel(v));
      end
   endtask

   // Ready follows the idle rate, except for one long hold-off asked for by the stimulus.
   initial begin
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            for (int held = 0; held < HOLD_CYCLES; held++) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_q.size() == 0) begin
            report_mismatch("result transaction with no candidate outstanding");
         end else begin
            verdict_head = verdict_q.pop_front();
            if (rsp_tdata[0] !== verdict_head.prime)
               report_mismatch($sformatf("candidate %0d: is_prime %b, expected %b",
                  $signed(verdict_head.candidate), rsp_tdata[0], verdict_head.prime));
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   initial begin
      word_type v;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PROBE_COUNT; i++) begin
         send_candidate(probes[i].candidate, probes[i].known ? probes[i].prime
                        : prime_by_wheel(probes[i].candidate));
      end
      send_random(25);

      send_idle_pct = 75;
      rsp_idle_pct  = 33;
      send_random(25);

      // The receiver stalls while cheap candidates keep coming, so the block backs up.
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      hold_request  = 1'b1;
      for (int k = 0; k < 12; k++) begin
         v = (k % 2 == 0) ? ($urandom | 32'h8000_0000) : ($urandom & 32'hFFFF_FFFE);
         send_candidate(v, prime_by_wheel(v));
      end
      send_random(25);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
